@@ rtl/core/stt_pkg.sv @@
// Shared definitions for the software timer table.
// Holds field widths, stream packing widths, request and event codes.
// No dependencies; imported by software_timer_table, stt_checker and the testbench.
package stt_pkg;

	// Default sizes handed to the top level.
	localparam int DEF_TIMER_SLOTS = 32;
	localparam int DEF_COUNT_BITS  = 32;

	// Fixed field widths of the stream words.
	localparam int FUNC_W = 3;
	localparam int SLOT_W = 5;
	localparam int TC_W   = 32;
	localparam int TAG_W  = 32;
	localparam int EVT_W  = 2;

	// Packed stream widths, rounded up to whole bytes.
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 40;
	localparam int M_PAD_W   = M_TDATA_W - SLOT_W - TAG_W - 1;

	// Request codes carried on the input tuser.
	localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_CREATE  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_DESTROY = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_RESET   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_SLEEP   = 3'd4;

	// Event codes carried on the output tuser.
	localparam logic [EVT_W-1:0] EVT_DONE  = 2'd0;
	localparam logic [EVT_W-1:0] EVT_FIRED = 2'd1;
	localparam logic [EVT_W-1:0] EVT_FULL  = 2'd2;

endpackage

@@ rtl/core/stt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the per-slot count and tag stores of the timer table.
// No dependencies.
module stt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/software_timer_table.sv @@
// Top level of the software timer table: request decode, slot sequencer, result register.
// Depends on stt_pkg and stt_ram.
//
// Usage:
// Requests enter on the s_ channel. s_tuser carries the request code (tick, create,
// destroy, reset count, start sleep); s_tdata carries slot, tick count and tag.
// Results leave on the m_ channel. m_tuser carries the event code (done, fired,
// table full), m_tdata carries slot, tag and the sleeping flag, and m_tlast marks
// the final word of a request. Every request ends with exactly one last word.
// One request is worked on at a time; s_tready is high only while the block waits.
// A tick walks the slots through one shared decrementer, one slot per cycle while
// no fired word waits on a stalled receiver, with each slot's count and tag read
// from the RAMs before its check; the done word follows the last slot.
// A create searches for the lowest free slot one slot per cycle. Destroy, reset
// count and sleep are applied when accepted and then end in a done word.
// One output register parts the two sides; when a slot fires while it is held by
// a stalled receiver, the slot walk pauses in place and resumes when the word is taken.
// Reset clears all slots to free and the sleep countdown to zero; no clearing
// pass is needed since a slot's count and tag are only used while a create holds it active.
module software_timer_table #(
	parameter int TIMER_SLOTS = stt_pkg::DEF_TIMER_SLOTS,
	parameter int COUNT_BITS  = stt_pkg::DEF_COUNT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata: slot[4:0], tick_count[36:5], tag[68:37], zero pad above.
	input  logic [stt_pkg::S_TDATA_W-1:0]  s_tdata,
	// s_tuser: func[2:0].
	input  logic [stt_pkg::FUNC_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata: fired_slot[4:0], fired_tag[36:5], sleeping[37], zero pad above.
	output logic [stt_pkg::M_TDATA_W-1:0]  m_tdata,
	// m_tuser: event_res[1:0].
	output logic [stt_pkg::EVT_W-1:0]      m_tuser,
	output logic                           m_tlast
);
	import stt_pkg::*;

	localparam int IDX_W   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W   = IDX_W + 1;
	localparam int SLEEP_W = COUNT_BITS + 1;
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TIMER_SLOTS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_TICK,
		S_FIND,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [TIMER_SLOTS-1:0]  active_q;
	logic [SLEEP_W-1:0]      sleep_q;
	logic [CNT_W-1:0]        rd_idx_q;
	logic                    chk_vld_s1;
	logic [IDX_W-1:0]        chk_idx_s1;
	logic [COUNT_BITS-1:0]   count_q;
	logic [TAG_W-1:0]        tag_q;

	logic                    out_vld_q;
	logic [EVT_W-1:0]        out_evt_q;
	logic [SLOT_W-1:0]       out_slot_q;
	logic [TAG_W-1:0]        out_tag_q;
	logic                    out_sleep_q;
	logic                    out_last_q;

	// Unpacked request word.
	logic [FUNC_W-1:0]       in_func;
	logic [SLOT_W-1:0]       in_slot;
	logic [COUNT_BITS-1:0]   in_count;
	logic [TAG_W-1:0]        in_tag;
	logic [IDX_W-1:0]        in_idx;
	logic                    in_slot_ok;

	assign in_func    = s_tuser;
	assign in_slot    = s_tdata[SLOT_W-1:0];
	assign in_count   = s_tdata[SLOT_W +: COUNT_BITS];
	assign in_tag     = s_tdata[SLOT_W + TC_W +: TAG_W];
	assign in_idx     = IDX_W'(in_slot);
	assign in_slot_ok = (32'(in_slot) < 32'(TIMER_SLOTS));

	// RAM ports.
	logic                    cnt_we;
	logic [IDX_W-1:0]        cnt_waddr;
	logic [COUNT_BITS-1:0]   cnt_wdata;
	logic                    tag_we;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	logic [COUNT_BITS-1:0]   rd_cnt;
	logic [TAG_W-1:0]        rd_tag;

	// Shared decrementer and slot check on the word last read from the RAMs.
	logic                    out_free;
	logic                    chk_live;
	logic                    chk_fire;
	logic                    stall;
	logic [COUNT_BITS-1:0]   cnt_dec;
	logic [IDX_W-1:0]        find_idx;
	logic                    find_free;

	assign out_free  = !out_vld_q || m_tready;
	assign cnt_dec   = rd_cnt - COUNT_BITS'(1);
	assign chk_live  = chk_vld_s1 && active_q[chk_idx_s1] && (rd_cnt != '0);
	assign chk_fire  = chk_live && (rd_cnt == COUNT_BITS'(1));
	assign stall     = chk_fire && !out_free;
	assign find_idx  = rd_idx_q[IDX_W-1:0];
	assign find_free = !active_q[find_idx];
	assign s_tready  = (state_q == S_IDLE);

	// RAM control for each phase of the sequencer.
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = chk_idx_s1;
		cnt_wdata = cnt_dec;
		tag_we    = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = rd_idx_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && (in_func == FUNC_RESET) && in_slot_ok) begin
					cnt_we    = 1'b1;
					cnt_waddr = in_idx;
					cnt_wdata = in_count;
				end
			end
			S_TICK: begin
				cnt_we = chk_live && !stall;
				rd_en  = !stall && (rd_idx_q < SLOTS_C);
			end
			S_FIND: begin
				if (find_free && out_free) begin
					cnt_we    = 1'b1;
					cnt_waddr = find_idx;
					cnt_wdata = count_q;
					tag_we    = 1'b1;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Per-slot count store.
	stt_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (TIMER_SLOTS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_cnt)
	);

	// Per-slot tag store, written only on create.
	stt_ram #(
		.WIDTH (TAG_W),
		.DEPTH (TIMER_SLOTS)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (find_idx),
		.wdata (tag_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_tag)
	);

	// Sequencer, slot state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= '0;
			sleep_q     <= '0;
			rd_idx_q    <= '0;
			chk_vld_s1  <= 1'b0;
			chk_idx_s1  <= '0;
			count_q     <= '0;
			tag_q       <= '0;
			out_vld_q   <= 1'b0;
			out_evt_q   <= EVT_DONE;
			out_slot_q  <= '0;
			out_tag_q   <= '0;
			out_sleep_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						rd_idx_q   <= '0;
						chk_vld_s1 <= 1'b0;
						count_q    <= in_count;
						tag_q      <= in_tag;
						unique case (in_func)
							FUNC_TICK: begin
								if (sleep_q != '0) begin
									sleep_q <= sleep_q - SLEEP_W'(1);
								end
								state_q <= S_TICK;
							end
							FUNC_CREATE: begin
								state_q <= S_FIND;
							end
							FUNC_DESTROY: begin
								if (in_slot_ok) begin
									active_q[in_idx] <= 1'b0;
								end
								state_q <= S_DONE;
							end
							FUNC_SLEEP: begin
								sleep_q <= SLEEP_W'(in_count) + SLEEP_W'(1);
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_TICK: begin
					if (!stall) begin
						// A slot that just reached zero reports its slot and tag.
						if (chk_fire) begin
							out_vld_q   <= 1'b1;
							out_evt_q   <= EVT_FIRED;
							out_slot_q  <= SLOT_W'(chk_idx_s1);
							out_tag_q   <= rd_tag;
							out_sleep_q <= (sleep_q != '0);
							out_last_q  <= 1'b0;
						end
						if (rd_idx_q < SLOTS_C) begin
							chk_vld_s1 <= 1'b1;
							chk_idx_s1 <= rd_idx_q[IDX_W-1:0];
							rd_idx_q   <= rd_idx_q + CNT_W'(1);
						end else begin
							chk_vld_s1 <= 1'b0;
							if (!chk_vld_s1) begin
								state_q <= S_DONE;
							end
						end
					end
				end
				S_FIND: begin
					// Lowest free slot wins; the last slot busy means the table is full.
					if (find_free) begin
						if (out_free) begin
							active_q[find_idx] <= 1'b1;
							out_vld_q   <= 1'b1;
							out_evt_q   <= EVT_DONE;
							out_slot_q  <= SLOT_W'(find_idx);
							out_tag_q   <= '0;
							out_sleep_q <= (sleep_q != '0);
							out_last_q  <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else if (rd_idx_q == SLOTS_C - CNT_W'(1)) begin
						if (out_free) begin
							out_vld_q   <= 1'b1;
							out_evt_q   <= EVT_FULL;
							out_slot_q  <= '0;
							out_tag_q   <= '0;
							out_sleep_q <= (sleep_q != '0);
							out_last_q  <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_vld_q   <= 1'b1;
						out_evt_q   <= EVT_DONE;
						out_slot_q  <= '0;
						out_tag_q   <= '0;
						out_sleep_q <= (sleep_q != '0);
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result word.
	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_evt_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_sleep_q, out_tag_q, out_slot_q};

endmodule

@@ rtl/core/stt_checker.sv @@
// Port-level checks for the software timer table, attached by the bind below.
// Depends on stt_pkg and on the top level software_timer_table.
module stt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [stt_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic [stt_pkg::EVT_W-1:0]      m_tuser,
	input logic                           m_tlast
);
	import stt_pkg::*;

	// A stalled result word holds still.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result word changed");

	// The block works on one request at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// A fired word is never the final word of its request.
	a_fired: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EVT_FIRED) |-> !m_tlast)
		else $error("fired word marked last");

	// Done and table-full words always close their request; table full names no slot.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EVT_DONE || m_tuser == EVT_FULL) |->
			m_tlast && (m_tuser == EVT_DONE || m_tdata[SLOT_W-1:0] == '0))
		else $error("closing word malformed");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for software_timer_table: directed and random requests
// with random stalls on both streams. Depends on stt_pkg and the block's RTL.
module tb_top;
	import stt_pkg::*;

	localparam int NSLOTS          = DEF_TIMER_SLOTS;
	localparam int RANDOM_REQUESTS = 370;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int DRAIN_CYCLES    = NSLOTS + 8;

	// Request codes that the block does not define; they still end in a done word.
	localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

	localparam logic [TC_W-1:0]  COUNT_MAX = '1;
	localparam logic [TAG_W-1:0] TAG_MIN   = {1'b1, {(TAG_W-1){1'b0}}};
	localparam logic [TAG_W-1:0] TAG_MAX   = {1'b0, {(TAG_W-1){1'b1}}};

	// One result word as the block should present it.
	typedef struct packed {
		logic [EVT_W-1:0]  evt;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  tag;
		logic              sleeping;
		logic              last;
	} timer_word_t;

	// Mirror of the timer table and queue of result words still owed by the block.
	class timer_scoreboard;
		bit                busy_slot[NSLOTS];
		bit [TC_W-1:0]     count_left[NSLOTS];
		bit [TAG_W-1:0]    owner_tag[NSLOTS];
		bit [TC_W:0]       sleep_left;
		timer_word_t       pending[$];
		int                failures;

		function new();
			foreach (busy_slot[i]) begin
				busy_slot[i] = 1'b0;
				count_left[i] = '0;
				owner_tag[i] = '0;
			end
			sleep_left = '0;
			failures = 0;
		endfunction

		// The sleeping flag reflects the sleep countdown at the moment the word is made.
		function void owe_word(logic [EVT_W-1:0] evt, int slot, logic [TAG_W-1:0] tag,
				logic last);
			timer_word_t w;
			w.evt = evt;
			w.slot = slot[SLOT_W-1:0];
			w.tag = tag;
			w.sleeping = (sleep_left != 0);
			w.last = last;
			pending.push_back(w);
		endfunction

		// Applies one accepted request to the mirror and queues the words it causes.
		function void note_request(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] slot,
				logic [TC_W-1:0] count, logic [TAG_W-1:0] tag);
			int free_slot;
			free_slot = -1;
			case (func)
			FUNC_TICK: begin
				if (sleep_left != 0)
					sleep_left--;
				for (int i = 0; i < NSLOTS; i++) begin
					if (busy_slot[i] && count_left[i] != 0) begin
						count_left[i]--;
						if (count_left[i] == 0)
							owe_word(EVT_FIRED, i, owner_tag[i], 1'b0);
					end
				end
			end
			FUNC_CREATE: begin
				for (int i = NSLOTS - 1; i >= 0; i--) begin
					if (!busy_slot[i])
						free_slot = i;
				end
				if (free_slot < 0) begin
					owe_word(EVT_FULL, 0, '0, 1'b1);
				end else begin
					busy_slot[free_slot] = 1'b1;
					count_left[free_slot] = count;
					owner_tag[free_slot] = tag;
					owe_word(EVT_DONE, free_slot, '0, 1'b1);
				end
				return;
			end
			FUNC_DESTROY: begin
				if (slot < NSLOTS)
					busy_slot[slot] = 1'b0;
			end
			FUNC_RESET: begin
				if (slot < NSLOTS)
					count_left[slot] = count;
			end
			FUNC_SLEEP: begin
				sleep_left = {1'b0, count} + 1'b1;
			end
			default: begin
			end
			endcase
			owe_word(EVT_DONE, 0, '0, 1'b1);
		endfunction

		function void flag(string field, logic [TAG_W-1:0] want, logic [TAG_W-1:0] got);
			failures++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		endfunction

		// Compares one accepted result word with the oldest one owed.
		function void check_word(logic [EVT_W-1:0] evt, logic [M_TDATA_W-1:0] data,
				logic last);
			timer_word_t want;
			if (pending.size() == 0) begin
				failures++;
				$display("%0t: expected no word, got event %0h slot %0h tag %0h last %0h",
					$time, evt, data[SLOT_W-1:0], data[SLOT_W +: TAG_W], last);
				return;
			end
			want = pending.pop_front();
			if (evt !== want.evt)
				flag("event", want.evt, evt);
			if (data[SLOT_W-1:0] !== want.slot)
				flag("slot", want.slot, data[SLOT_W-1:0]);
			if (data[SLOT_W +: TAG_W] !== want.tag)
				flag("tag", want.tag, data[SLOT_W +: TAG_W]);
			if (data[SLOT_W+TAG_W] !== want.sleeping)
				flag("sleeping", want.sleeping, data[SLOT_W+TAG_W]);
			if (last !== want.last)
				flag("last", want.last, last);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [FUNC_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [EVT_W-1:0]      m_tuser;
	logic                  m_tlast;

	timer_scoreboard sb;
	bit send_burst;
	bit sink_burst;
	int cycles;

	software_timer_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Idle cycles before a word; none at all while a side runs in a burst.
	function automatic int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, 9);
	endfunction

	// Mostly short countdowns so that timers fire often, with some huge ones.
	function automatic logic [TC_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 4);
		else if (r < 85)
			return $urandom_range(5, 40);
		else if (r < 95)
			return $urandom;
		return COUNT_MAX;
	endfunction

	// Usually a slot in use, sometimes any slot, so free slots get hit as well.
	function automatic logic [SLOT_W-1:0] pick_slot();
		int taken[$];
		for (int i = 0; i < NSLOTS; i++) begin
			if (sb.busy_slot[i])
				taken.push_back(i);
		end
		if (taken.size() == 0 || $urandom_range(0, 4) == 0)
			return SLOT_W'($urandom_range(0, NSLOTS - 1));
		return SLOT_W'(taken[$urandom_range(0, taken.size() - 1)]);
	endfunction

	// Presents one request word and returns at the edge that accepts it.
	// Valid stays high into the next request when no gap is drawn.
	task automatic send_request(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
			input logic [TC_W-1:0] count, input logic [TAG_W-1:0] tag);
		int gap;
		gap = draw_gap(send_burst);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {{(S_TDATA_W-SLOT_W-TC_W-TAG_W){1'b0}}, tag, count, slot};
		do @(posedge clk); while (!s_tready);
		sb.note_request(func, slot, count, tag);
		if ($urandom_range(0, 29) == 0)
			send_burst = !send_burst;
	endtask

	// Edge values: empty ticks, spare codes, count and tag extremes, zero counts,
	// resets on live and free slots, reuse of the lowest free slot, and sleep.
	task automatic run_directed();
		send_request(FUNC_TICK, '0, '0, '0);
		for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
			send_request(FUNC_W'(f), '1, COUNT_MAX, '1);
		send_request(FUNC_CREATE, '0, 1, TAG_MAX);
		send_request(FUNC_CREATE, '0, 0, TAG_MIN);
		send_request(FUNC_CREATE, '0, COUNT_MAX, '1);
		send_request(FUNC_CREATE, '0, 2, '0);
		send_request(FUNC_SLEEP, '0, 0, '0);
		send_request(FUNC_TICK, '0, '0, '0);
		send_request(FUNC_TICK, '0, '0, '0);
		send_request(FUNC_RESET, SLOT_W'(1), 1, '0);
		send_request(FUNC_RESET, SLOT_W'(NSLOTS - 1), 5, '0);
		send_request(FUNC_TICK, '0, '0, '0);
		send_request(FUNC_DESTROY, SLOT_W'(2), '0, '0);
		send_request(FUNC_DESTROY, SLOT_W'(NSLOTS - 1), '0, '0);
		send_request(FUNC_CREATE, '0, 1, $urandom);
		send_request(FUNC_SLEEP, '0, COUNT_MAX, '0);
		send_request(FUNC_TICK, '0, '0, '0);
		send_request(FUNC_SLEEP, '0, 1, '0);
		send_request(FUNC_TICK, '0, '0, '0);
		send_request(FUNC_TICK, '0, '0, '0);
	endtask

	// Alternates create-heavy phases that fill the table up to full with
	// destroy-heavy phases that empty it, ticking throughout.
	task automatic run_random();
		bit filling;
		int phase_left;
		int r;
		int cut_create;
		int cut_tick;
		int cut_destroy;
		int cut_reset;
		int cut_sleep;
		logic [FUNC_W-1:0] func;
		filling = 1'b1;
		phase_left = $urandom_range(30, 80);
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (phase_left == 0) begin
				filling = !filling;
				phase_left = $urandom_range(30, 80);
			end
			phase_left--;
			cut_create = filling ? 55 : 10;
			cut_tick = cut_create + (filling ? 30 : 35);
			cut_destroy = cut_tick + (filling ? 3 : 35);
			cut_reset = cut_destroy + (filling ? 5 : 8);
			cut_sleep = cut_reset + (filling ? 4 : 7);
			r = $urandom_range(0, 99);
			if (r < cut_create)
				func = FUNC_CREATE;
			else if (r < cut_tick)
				func = FUNC_TICK;
			else if (r < cut_destroy)
				func = FUNC_DESTROY;
			else if (r < cut_reset)
				func = FUNC_RESET;
			else if (r < cut_sleep)
				func = FUNC_SLEEP;
			else
				func = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
			send_request(func, pick_slot(), pick_count(), $urandom);
		end
	endtask

	// Receiver: stalls a random number of cycles before each word.
	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(sink_burst);
			@(negedge clk);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if ($urandom_range(0, 29) == 0)
				sink_burst = !sink_burst;
		end
	end

	// Check every result word at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tuser, m_tdata, m_tlast);
	end

	// Guard against a hung block.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= FUNC_TICK;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
